[rtl/lfruscp_pkg.sv]
package lfruscp_pkg;

   // Table geometry.
   localparam int SLOTS = 256;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = IDX_W + 1;

   // Field widths fixed by the interface.
   localparam int LAYER_W   = 7;
   localparam int EXPERT_W  = 9;
   localparam int CFG_W     = 9;
   localparam int OCC_W     = 9;
   localparam int IDX_OUT_W = 8;
   localparam int CTR_W     = 32;

   // Scoring.
   localparam int FRESH_W   = 8;
   localparam int FRESH_MAX = 255;
   localparam int SCORE_W   = CTR_W + FRESH_W;
   localparam int THR_W     = SCORE_W + 1;
   localparam int THR_BIAS  = 4 << FRESH_W;

   localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(256);

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_TOUCH  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic [LAYER_W-1:0]  layer;
      logic [EXPERT_W-1:0] expert;
      logic [CTR_W-1:0]    heat;
      logic [CTR_W-1:0]    stamp;
   } slot_entry_type;

endpackage

[rtl/lfru_slot_cache_policy.sv]
// Slot cache with LFRU replacement, keyed by (layer, expert).
//
// Requests arrive on req_opcode, req_layer_id and req_expert_id and are
// taken at a rising edge where start is high and busy is low: lookup, insert
// or touch. Each request gives exactly one response, shown on the rsp_ ports
// for a single cycle while rsp_valid is high; the receiver must take it then,
// as it cannot hold a response off.
// The capacity register is written through csr_wr_en and csr_wr_data; values
// above the table size act as the table size. The user must write it only while
// the block is idle; the block itself does not enforce this.
// Every request makes one pass over the active slots, reading one slot entry
// per cycle from the table memory and feeding a shared two-stage match and
// score unit. A new request can be taken at the edge that ends the response
// cycle, so the block is through with one request before it takes the next.
// The pass length is set by the one memory read port.
// Synchronous reset clears all valid bits, the recency clock, the occupancy
// count and the statistics counters, and restores full capacity. No clearing
// pass over the table memory is needed, as entries are used only when valid.
module lfru_slot_cache_policy (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_opcode,
   input  logic [lfruscp_pkg::LAYER_W-1:0]   req_layer_id,
   input  logic [lfruscp_pkg::EXPERT_W-1:0]  req_expert_id,
   input  logic                              csr_wr_en,
   input  logic [lfruscp_pkg::CFG_W-1:0]     csr_wr_data,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic [lfruscp_pkg::IDX_OUT_W-1:0] rsp_slot_index,
   output logic                              rsp_evicted,
   output logic [lfruscp_pkg::LAYER_W-1:0]   rsp_victim_layer,
   output logic [lfruscp_pkg::EXPERT_W-1:0]  rsp_victim_expert,
   output logic [lfruscp_pkg::OCC_W-1:0]     rsp_occupied_count,
   output logic [lfruscp_pkg::CTR_W-1:0]     rsp_hit_total,
   output logic [lfruscp_pkg::CTR_W-1:0]     rsp_miss_total,
   output logic [lfruscp_pkg::CTR_W-1:0]     rsp_eviction_total
);

   import lfruscp_pkg::*;

   // Control state.
   state_type           state_ff, state_in;
   logic [CFG_W-1:0]    active_ff;
   logic [SLOTS-1:0]    valid_ff;
   logic [CNT_W-1:0]    n_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CTR_W-1:0]    clock_ff;
   logic [CNT_W-1:0]    valid_count_ff;
   logic [CTR_W-1:0]    hit_counter_ff;
   logic [CTR_W-1:0]    miss_counter_ff;
   logic [CTR_W-1:0]    evict_counter_ff;
   logic                rsp_valid_ff;

   // Latched request.
   op_type              op_ff;
   logic [LAYER_W-1:0]  layer_ff;
   logic [EXPERT_W-1:0] expert_ff;

   // Scan pipeline.
   logic                p1_ff;
   logic [IDX_W-1:0]    p1_idx_ff;
   logic                p1_vld_ff;
   logic                p2_ff;
   logic [IDX_W-1:0]    p2_idx_ff;
   logic [SCORE_W-1:0]  p2_score_ff;
   logic [LAYER_W-1:0]  p2_layer_ff;
   logic [EXPERT_W-1:0] p2_expert_ff;

   // Scan findings.
   logic                match_found_ff;
   logic [IDX_W-1:0]    match_idx_ff;
   logic [CTR_W-1:0]    match_heat_ff;
   logic                free_found_ff;
   logic [IDX_W-1:0]    free_idx_ff;
   logic                cand_found_ff;
   logic [IDX_W-1:0]    cand_idx_ff;
   logic [LAYER_W-1:0]  cand_layer_ff;
   logic [EXPERT_W-1:0] cand_expert_ff;
   logic [THR_W-1:0]    thr_ff;

   // Registered response payload.
   logic                 rsp_hit_ff;
   logic [IDX_W-1:0]     rsp_idx_ff;
   logic                 rsp_evicted_ff;
   logic [LAYER_W-1:0]   rsp_victim_layer_ff;
   logic [EXPERT_W-1:0]  rsp_victim_expert_ff;

   logic                 accept;
   logic                 issue;
   logic                 commit;
   logic [CNT_W-1:0]     live_slots;
   slot_entry_type       rd_entry;
   logic [SLOTS*0+$bits(slot_entry_type)-1:0] rd_word;
   logic                 tag_match;
   logic [CTR_W-1:0]     age;
   logic [FRESH_W-1:0]   fresh;
   logic [THR_W-1:0]     thr_new;
   logic                 cand_win;

   // Commit decisions.
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_idx;
   slot_entry_type       wr_entry;
   logic                 res_hit;
   logic                 res_evicted;
   logic [CTR_W-1:0]     clock_next;

   assign accept     = start && !busy;
   assign live_slots = (32'(active_ff) > 32'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(active_ff);
   assign issue      = (state_ff == ST_SCAN) && (cnt_ff < n_ff);
   assign commit     = (state_ff == ST_COMMIT);
   assign clock_next = clock_ff + CTR_W'(1);

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((cnt_ff == n_ff) && !p1_ff && !p2_ff) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Slot table: tags, heat and stamp of every slot in one memory word.
   lfruscp_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_entry),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (rd_word)
   );

   assign rd_entry = slot_entry_type'(rd_word);

   // Stage one: tag compare and score of the entry just read.
   assign tag_match = p1_vld_ff && (rd_entry.layer == layer_ff) &&
                      (rd_entry.expert == expert_ff);
   assign age       = clock_ff - rd_entry.stamp;
   assign fresh     = (age < CTR_W'(FRESH_MAX)) ? FRESH_W'(CTR_W'(FRESH_MAX) - age)
                                                : '0;

   // Stage two: hysteresis compare against the current candidate. A negative
   // threshold stands for the wrapped case, where the later slot always wins.
   assign cand_win = !cand_found_ff || thr_ff[THR_W-1] || (p2_score_ff < thr_ff[SCORE_W-1:0]);
   assign thr_new  = {1'b0, p2_score_ff} - THR_W'(p2_score_ff >> 2) - THR_W'(THR_BIAS);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         p1_ff          <= 1'b0;
         p2_ff          <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         cand_found_ff  <= 1'b0;
      end else if (accept) begin
         cnt_ff         <= '0;
         p1_ff          <= 1'b0;
         p2_ff          <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         cand_found_ff  <= 1'b0;
      end else begin
         p1_ff <= issue;
         p2_ff <= p1_ff && p1_vld_ff;
         if (issue) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (p1_ff && tag_match && !match_found_ff) begin
            match_found_ff <= 1'b1;
         end
         if (p1_ff && !p1_vld_ff && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
         if (p2_ff && cand_win) begin
            cand_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= op_type'(req_opcode);
         layer_ff  <= req_layer_id;
         expert_ff <= req_expert_id;
         n_ff      <= live_slots;
      end
      p1_idx_ff    <= cnt_ff[IDX_W-1:0];
      p1_vld_ff    <= valid_ff[cnt_ff[IDX_W-1:0]];
      p2_idx_ff    <= p1_idx_ff;
      p2_score_ff  <= {rd_entry.heat, fresh};
      p2_layer_ff  <= rd_entry.layer;
      p2_expert_ff <= rd_entry.expert;
      if (p1_ff && tag_match && !match_found_ff) begin
         match_idx_ff  <= p1_idx_ff;
         match_heat_ff <= rd_entry.heat;
      end
      if (p1_ff && !p1_vld_ff && !free_found_ff) begin
         free_idx_ff <= p1_idx_ff;
      end
      if (p2_ff && cand_win) begin
         cand_idx_ff    <= p2_idx_ff;
         cand_layer_ff  <= p2_layer_ff;
         cand_expert_ff <= p2_expert_ff;
         thr_ff         <= thr_new;
      end
   end

   // Commit: at most one table write and the counter updates, decided from the scan.
   always_comb begin
      wr_en          = 1'b0;
      wr_idx         = free_idx_ff;
      wr_entry.layer  = layer_ff;
      wr_entry.expert = expert_ff;
      wr_entry.heat   = CTR_W'(1);
      wr_entry.stamp  = clock_next;
      res_hit        = 1'b0;
      res_evicted    = 1'b0;
      if (commit) begin
         unique case (op_ff)
            OP_LOOKUP, OP_TOUCH: begin
               if (match_found_ff) begin
                  wr_en         = 1'b1;
                  wr_idx        = match_idx_ff;
                  wr_entry.heat = (match_heat_ff == '1) ? match_heat_ff
                                                        : match_heat_ff + CTR_W'(1);
                  res_hit       = 1'b1;
               end
            end
            OP_INSERT: begin
               priority if (free_found_ff) begin
                  wr_en   = 1'b1;
                  wr_idx  = free_idx_ff;
                  res_hit = 1'b1;
               end else if (cand_found_ff) begin
                  wr_en       = 1'b1;
                  wr_idx      = cand_idx_ff;
                  res_hit     = 1'b1;
                  res_evicted = 1'b1;
               end else begin
                  wr_en = 1'b0;
               end
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff        <= ACTIVE_RESET;
         valid_ff         <= '0;
         clock_ff         <= '0;
         valid_count_ff   <= '0;
         hit_counter_ff   <= '0;
         miss_counter_ff  <= '0;
         evict_counter_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
         rsp_valid_ff <= commit;
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
            clock_ff         <= clock_next;
         end
         if (commit && (op_ff == OP_INSERT) && free_found_ff) begin
            valid_count_ff <= valid_count_ff + CNT_W'(1);
         end
         if (res_evicted) begin
            evict_counter_ff <= evict_counter_ff + CTR_W'(1);
         end
         if (commit && (op_ff == OP_LOOKUP)) begin
            if (match_found_ff) begin
               hit_counter_ff <= hit_counter_ff + CTR_W'(1);
            end else begin
               miss_counter_ff <= miss_counter_ff + CTR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_hit_ff           <= res_hit;
         rsp_idx_ff           <= res_hit ? wr_idx : '0;
         rsp_evicted_ff       <= res_evicted;
         rsp_victim_layer_ff  <= res_evicted ? cand_layer_ff : '0;
         rsp_victim_expert_ff <= res_evicted ? cand_expert_ff : '0;
      end
   end

   // The counters change only at commit, so they already hold the values
   // after this request while the response is shown.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_slot_index     = IDX_OUT_W'(rsp_idx_ff);
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_victim_layer   = rsp_victim_layer_ff;
   assign rsp_victim_expert  = rsp_victim_expert_ff;
   assign rsp_occupied_count = OCC_W'(valid_count_ff);
   assign rsp_hit_total      = hit_counter_ff;
   assign rsp_miss_total     = miss_counter_ff;
   assign rsp_eviction_total = evict_counter_ff;

   // The occupancy count must track the valid bits exactly.
   assert property (@(posedge clock) disable iff (reset)
      32'($countones(valid_ff)) == 32'(valid_count_ff))
      else $error("occupancy count differs from the number of valid slots");

   // A response follows only from a commit cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_COMMIT))
      else $error("response shown without a commit");

   // An accepted request makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after accepting a request");

   // An eviction is always part of a completed insert.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> rsp_hit)
      else $error("eviction reported without a completed insert");

endmodule

[rtl/lfruscp_ram.sv]
module lfruscp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
